// ===== hdl/ssuic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted set union/intersection/complement - shared definitions
// Sizes, mode codes, the insertion chain's control group and the run test.
// ---------------------------------------------------------------------------
package ssuic_pkg;

    localparam int SET_CAPACITY = 32;
    localparam int STORE_DEPTH  = 64;
    localparam int MAX_RESULTS  = 64;

    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;
    localparam int SETCNT_W = $clog2(SET_CAPACITY + 1);
    localparam int FILL_W   = $clog2(STORE_DEPTH + 1);
    localparam int FOUND_W  = $clog2(MAX_RESULTS + 1);
    localparam int RUN_W    = 2;

    localparam logic [MODE_W-1:0] MODE_UNION = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INTER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPL = 2'd2;

    // Broadcast control for every cell of the chain
    typedef struct packed {
        logic                     insert;
        logic                     shift;
        logic                     clear;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

    // Decide whether a finished run of equal values belongs to the result.
    // The run length saturates at two.
    function automatic logic run_qualifies(input logic [MODE_W-1:0] mode,
                                           input logic [RUN_W-1:0]  run_len);
        logic q;
        begin
            case (mode)
                MODE_UNION: q = 1'b1;
                MODE_INTER: q = (run_len >= RUN_W'(2));
                MODE_COMPL: q = (run_len == RUN_W'(1));
                default:    q = 1'b0;
            endcase
            return q;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ssuic_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted set union/intersection/complement - stream interfaces
// Input element channel and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface ssuic_in_if;
    import ssuic_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] element_value;
    logic                     set_select;
    logic                     has_value;
    logic                     last_item;

    modport source (output valid, element_value, set_select, has_value, last_item,
                    input ready);
    modport sink   (input valid, element_value, set_select, has_value, last_item,
                    output ready);
endinterface

interface ssuic_out_if;
    import ssuic_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic                     last_result;
    logic                     empty_result;
    logic                     overflow;

    modport source (output valid, result_value, last_result, empty_result, overflow,
                    input ready);
    modport sink   (input valid, result_value, last_result, empty_result, overflow,
                    output ready);
endinterface
`default_nettype wire

// ===== hdl/ssuic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted set union/intersection/complement - chain cell
// Holds one stored element. On insert it keeps, takes the new element or
// takes its left neighbor; on shift, its right neighbor; clear empties it.
// ---------------------------------------------------------------------------
module ssuic_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ssuic_pkg::cell_ctl_t              ctl,
    input  wire logic                              left_valid,
    input  wire logic                              left_gt,
    input  wire logic signed [ssuic_pkg::DATA_W-1:0] left_value,
    input  wire logic                              right_valid,
    input  wire logic signed [ssuic_pkg::DATA_W-1:0] right_value,
    output logic                                   valid,
    output logic                                   gt,
    output logic signed [ssuic_pkg::DATA_W-1:0]    value
);
    import ssuic_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    // An empty cell counts as greater than any new element
    assign gt    = !valid_reg || (value_reg > ctl.value);
    assign valid = valid_reg;
    assign value = value_reg;

    // Select the next content of the cell
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_next = right_valid;
            value_next = right_value;
        end
        else if (ctl.insert)
        begin
            if (left_gt && left_valid)
            begin
                valid_next = 1'b1;
                value_next = left_value;
            end
            else if (gt && !left_gt)
            begin
                valid_next = 1'b1;
                value_next = ctl.value;
            end
        end
    end

    // Hold occupancy under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
`default_nettype wire

// ===== hdl/ssuic_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted set union/intersection/complement - insertion chain
// A row of cells kept in ascending signed order; exposes the two head cells.
// ---------------------------------------------------------------------------
module ssuic_chain (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ssuic_pkg::cell_ctl_t              ctl,
    output logic                                   head_valid,
    output logic signed [ssuic_pkg::DATA_W-1:0]    head_value,
    output logic                                   next_valid,
    output logic signed [ssuic_pkg::DATA_W-1:0]    next_value
);
    import ssuic_pkg::*;

    logic                     valid_w [STORE_DEPTH+1];
    logic                     gt_w    [STORE_DEPTH];
    logic signed [DATA_W-1:0] value_w [STORE_DEPTH+1];

    // Boundary beyond the last cell: empty
    assign valid_w[STORE_DEPTH] = 1'b0;
    assign value_w[STORE_DEPTH] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < STORE_DEPTH; gi++)
        begin : g_cell
            logic                     lv;
            logic                     lg;
            logic signed [DATA_W-1:0] lval;

            if (gi == 0)
            begin : g_first
                assign lv   = 1'b0;
                assign lg   = 1'b0;
                assign lval = '0;
            end
            else
            begin : g_rest
                assign lv   = valid_w[gi-1];
                assign lg   = gt_w[gi-1];
                assign lval = value_w[gi-1];
            end

            ssuic_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .left_valid  (lv),
                .left_gt     (lg),
                .left_value  (lval),
                .right_valid (valid_w[gi+1]),
                .right_value (value_w[gi+1]),
                .valid       (valid_w[gi]),
                .gt          (gt_w[gi]),
                .value       (value_w[gi])
            );
        end
    endgenerate

    assign head_valid = valid_w[0];
    assign head_value = value_w[0];
    assign next_valid = valid_w[1];
    assign next_value = value_w[1];

endmodule
`default_nettype wire

// ===== hdl/sorted_set_union_intersect_complement.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted set union / intersection / complement
// Loads two tagged sets into a sorted insertion chain, then streams the
// result set in ascending order.
// ---------------------------------------------------------------------------
// Elements are accepted one per cycle while loading; each one is inserted as
// it is accepted by the row of STORE_DEPTH compare-and-shift cells. The beat
// with last_item set ends loading: from then on no input beat is accepted
// while the chain is shifted out through its head cell, one stored element
// per cycle unless the result sink stalls, and a closing step sends the
// final result. Results are held one behind the scan so the final one can
// carry last_result; an empty result gives one beat with empty_result set.
// Elements beyond SET_CAPACITY per set or STORE_DEPTH in total are dropped
// and reported through overflow on every result of that run. op_mode must
// be written only while the block is idle.
// ---------------------------------------------------------------------------
module sorted_set_union_intersect_complement (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ssuic_pkg::MODE_W-1:0]    cfg_wdata,
    ssuic_in_if.sink                             in_ch,
    ssuic_out_if.source                          out_ch
);
    import ssuic_pkg::*;

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                     state_reg, state_next;
    logic [MODE_W-1:0]        mode_reg;
    logic [SETCNT_W-1:0]      first_cnt_reg, first_cnt_next;
    logic [SETCNT_W-1:0]      second_cnt_reg, second_cnt_next;
    logic                     ovf_reg, ovf_next;
    logic [RUN_W-1:0]         run_reg, run_next;
    logic [FOUND_W-1:0]       found_reg, found_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic signed [DATA_W-1:0] pend_value_reg, pend_value_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_empty_reg, out_empty_next;
    logic                     out_ovf_reg, out_ovf_next;

    cell_ctl_t                ctl;
    logic                     head_valid, next_valid;
    logic signed [DATA_W-1:0] head_value, next_value;

    logic                     in_fire;
    logic                     out_free;
    logic [FILL_W-1:0]        fill;
    logic                     fits;
    logic [RUN_W-1:0]         run_len;
    logic                     run_ends;
    logic                     qual;
    logic                     scan_done;

    ssuic_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .head_valid (head_valid),
        .head_value (head_value),
        .next_valid (next_valid),
        .next_value (next_value)
    );

    assign in_ch.ready  = (state_reg == ST_LOAD);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;

    assign fill = FILL_W'(first_cnt_reg) + FILL_W'(second_cnt_reg);
    assign fits = (in_ch.set_select ? (second_cnt_reg < SETCNT_W'(SET_CAPACITY))
                                    : (first_cnt_reg < SETCNT_W'(SET_CAPACITY)))
                  && (fill < FILL_W'(STORE_DEPTH));

    // Run tracking at the head of the chain
    assign run_len   = (run_reg == RUN_W'(2)) ? RUN_W'(2) : run_reg + RUN_W'(1);
    assign run_ends  = !next_valid || (next_value != head_value);
    assign qual      = run_ends && run_qualifies(mode_reg, run_len);
    assign scan_done = !head_valid || (found_reg == FOUND_W'(MAX_RESULTS));

    // Load, scan and emit control
    always_comb
    begin
        state_next      = state_reg;
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        ovf_next        = ovf_reg;
        run_next        = run_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;

        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_ovf_next    = out_ovf_reg;

        ctl.insert = 1'b0;
        ctl.shift  = 1'b0;
        ctl.clear  = 1'b0;
        ctl.value  = in_ch.element_value;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (in_ch.has_value)
                    begin
                        if (fits)
                        begin
                            ctl.insert = 1'b1;
                            if (in_ch.set_select)
                                second_cnt_next = second_cnt_reg + SETCNT_W'(1);
                            else
                                first_cnt_next = first_cnt_reg + SETCNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (in_ch.last_item)
                    begin
                        first_cnt_next  = '0;
                        second_cnt_next = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    // Send the held result as the final beat, or the empty marker
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_value_next  = pend_valid_reg ? pend_value_reg : '0;
                        out_last_next   = 1'b1;
                        out_empty_next  = !pend_valid_reg;
                        out_ovf_next    = ovf_reg;
                        ctl.clear       = 1'b1;
                        ovf_next        = 1'b0;
                        run_next        = '0;
                        found_next      = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_LOAD;
                    end
                end
                else if (!(qual && pend_valid_reg && !out_free))
                begin
                    // Advance the chain by one element
                    ctl.shift = 1'b1;
                    run_next  = run_ends ? '0 : run_len;
                    if (qual)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = pend_value_reg;
                            out_last_next  = 1'b0;
                            out_empty_next = 1'b0;
                            out_ovf_next   = ovf_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_value_next = head_value;
                        found_next      = found_reg + FOUND_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            mode_reg       <= MODE_UNION;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            ovf_reg        <= 1'b0;
            run_reg        <= '0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
                mode_reg   <= cfg_wdata;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            ovf_reg        <= ovf_next;
            run_reg        <= run_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_value_reg <= pend_value_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
        out_ovf_reg    <= out_ovf_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_value = out_value_reg;
    assign out_ch.last_result  = out_last_reg;
    assign out_ch.empty_result = out_empty_reg;
    assign out_ch.overflow     = out_ovf_reg;

endmodule
`default_nettype wire

// ===== verif/tb_sorted_set_union_intersect_complement.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted set union/intersection/complement - testbench
// Streams tagged set elements into the block under every op_mode and checks
// each result beat against an in-bench sorted-merge model, under random
// source gaps and sink stalls.
// ---------------------------------------------------------------------------
import ssuic_pkg::*;

typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     set_sel;
    logic                     has_value;
    logic                     last_item;
} element_beat_t;

typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     empty;
    logic                     dropped;
} result_beat_t;

localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

// Sorted merge model of the block plus the queue of result beats it predicts
class set_merge_board;
    logic signed [DATA_W-1:0] merged[$];
    int unsigned              first_cnt;
    int unsigned              second_cnt;
    bit                       dropped;
    logic [MODE_W-1:0]        mode;
    result_beat_t             expected[$];
    int                       errors;
    int                       runs;
    int                       beats_seen;
    int                       overflow_runs;
    int                       mode_runs[4];

    function new();
        first_cnt     = 0;
        second_cnt    = 0;
        dropped       = 1'b0;
        mode          = MODE_UNION;
        errors        = 0;
        runs          = 0;
        beats_seen    = 0;
        overflow_runs = 0;
        foreach (mode_runs[m]) mode_runs[m] = 0;
    endfunction

    function int pending();
        return expected.size();
    endfunction

    function bit keeps_run(int run_len);
        case (mode)
            MODE_UNION: return 1'b1;
            MODE_INTER: return run_len >= 2;
            MODE_COMPL: return run_len == 1;
            default:    return 1'b0;
        endcase
    endfunction

    // Insert an accepted element; on the closing beat predict the whole run
    function void note_element(element_beat_t e);
        int           pos;
        int           total;
        int           i;
        int           run_len;
        int           found;
        result_beat_t r;
        if (e.has_value) begin
            if ((e.set_sel ? second_cnt : first_cnt) < SET_CAPACITY &&
                merged.size() < STORE_DEPTH) begin
                pos = merged.size();
                while (pos > 0 && merged[pos-1] > e.value)
                    pos--;
                merged.insert(pos, e.value);
                if (e.set_sel)
                    second_cnt++;
                else
                    first_cnt++;
            end
            else begin
                dropped = 1'b1;
            end
        end
        if (!e.last_item)
            return;

        // Scan runs of equal values in ascending order
        total = merged.size();
        i     = 0;
        found = 0;
        while (i < total && found < MAX_RESULTS) begin
            run_len = 1;
            while (i + run_len < total && merged[i + run_len] == merged[i])
                run_len++;
            if (keeps_run(run_len)) begin
                r.value   = merged[i];
                r.last    = 1'b0;
                r.empty   = 1'b0;
                r.dropped = dropped;
                expected.push_back(r);
                found++;
            end
            i += run_len;
        end
        if (found == 0) begin
            r.value   = '0;
            r.last    = 1'b1;
            r.empty   = 1'b1;
            r.dropped = dropped;
            expected.push_back(r);
        end
        else begin
            expected[expected.size() - 1].last = 1'b1;
        end

        runs++;
        mode_runs[mode]++;
        if (dropped)
            overflow_runs++;
        merged.delete();
        first_cnt  = 0;
        second_cnt = 0;
        dropped    = 1'b0;
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_result(result_beat_t got);
        result_beat_t want;
        beats_seen++;
        if (expected.size() == 0) begin
            report($sformatf("result beat %0d with nothing expected", got.value));
            return;
        end
        want = expected.pop_front();
        // The value carries no meaning on an empty-result beat
        if (!want.empty && got.value !== want.value)
            report($sformatf("result_value %0d, expected %0d", got.value, want.value));
        if (got.last !== want.last)
            report($sformatf("last_result %b, expected %b (value %0d)",
                             got.last, want.last, want.value));
        if (got.empty !== want.empty)
            report($sformatf("empty_result %b, expected %b", got.empty, want.empty));
        if (got.dropped !== want.dropped)
            report($sformatf("overflow %b, expected %b", got.dropped, want.dropped));
    endtask
endclass

module tb_sorted_set_union_intersect_complement;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 2 * STORE_DEPTH + 8;
    localparam int RANDOM_ITEMS  = 210;
    localparam int CALM_ITEMS    = 170;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = ~VAL_MIN;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [MODE_W-1:0] cfg_wdata;

    ssuic_in_if  in_ch();
    ssuic_out_if out_ch();

    set_merge_board board;
    result_beat_t   seen_beat;
    bit             idle_on = 1'b1;
    int             item_count = 0;
    logic [MODE_W-1:0] mode_list[4] = '{MODE_UNION, MODE_INTER, MODE_COMPL, MODE_UNUSED};

    sorted_set_union_intersect_complement dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Drive result ready with random stall bursts
    initial
    begin : result_sink
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                out_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 8) - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen_beat.value   = out_ch.result_value;
            seen_beat.last    = out_ch.last_result;
            seen_beat.empty   = out_ch.empty_result;
            seen_beat.dropped = out_ch.overflow;
            board.check_result(seen_beat);
        end
    end

    // Present one element beat, hold it until accepted, then note it
    task send_item(input logic signed [DATA_W-1:0] value, input logic sel,
                   input logic has, input logic last);
        element_beat_t e;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.element_value <= value;
        in_ch.set_select    <= sel;
        in_ch.has_value     <= has;
        in_ch.last_item     <= last;
        e.value     = value;
        e.set_sel   = sel;
        e.has_value = has;
        e.last_item = last;
        do @(posedge clk); while (!in_ch.ready);
        board.note_element(e);
        item_count++;
    endtask

    // Wait for the block to go idle, then write op_mode
    task write_mode(input logic [MODE_W-1:0] m);
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we     <= 1'b0;
        board.mode  = m;
    endtask

    // One load-and-emit run with random size and content
    task random_run();
        int                       n;
        int                       k;
        logic                     dom;
        logic                     sel;
        bit                       close_sep;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] used[$];
        if ($urandom_range(0, 7) == 0)
            n = $urandom_range(33, 70);
        else
            n = $urandom_range(0, 10);
        dom       = 1'($urandom_range(0, 1));
        close_sep = (n == 0) || ($urandom_range(0, 1) == 1);
        for (k = 0; k < n; k++)
        begin
            // Occasionally slip in a beat the block ignores
            if ($urandom_range(0, 9) == 0)
                send_item($urandom, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: v = int'($urandom_range(0, 15)) - 8;
                2: v = (used.size() != 0) ? used[$urandom_range(0, used.size() - 1)]
                                          : $urandom;
                default: v = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
            endcase
            // Big runs lean on one set so it fills up
            if (n > SET_CAPACITY)
                sel = ($urandom_range(0, 9) == 0) ? !dom : dom;
            else
                sel = 1'($urandom_range(0, 1));
            used.push_back(v);
            send_item(v, sel, 1'b1, !close_sep && (k == n - 1));
        end
        if (close_sep)
        begin
            send_item($urandom, 1'($urandom_range(0, 1)), 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        #1_000_000;
        $display("sorted_set_union_intersect_complement regression: fail");
        $finish;
    end

    initial
    begin
        board = new();
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.element_value <= '0;
        in_ch.set_select    <= 1'b0;
        in_ch.has_value     <= 1'b0;
        in_ch.last_item     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Union with the value extremes and a shared zero
        write_mode(MODE_UNION);
        send_item(VAL_MAX, 1'b0, 1'b1, 1'b0);
        send_item(VAL_MIN, 1'b0, 1'b1, 1'b0);
        send_item(0,       1'b0, 1'b1, 1'b0);
        send_item(0,       1'b1, 1'b1, 1'b0);
        send_item(-1,      1'b1, 1'b1, 1'b1);
        // Closing beat alone gives an empty result
        send_item(VAL_MAX, 1'b1, 1'b0, 1'b1);

        // Intersection with an ignored beat and a separate closing beat
        write_mode(MODE_INTER);
        send_item(5,   1'b0, 1'b1, 1'b0);
        send_item(-7,  1'b0, 1'b1, 1'b0);
        send_item(100, 1'b0, 1'b1, 1'b0);
        send_item(-1,  1'b1, 1'b0, 1'b0);
        send_item(100, 1'b1, 1'b1, 1'b0);
        send_item(5,   1'b1, 1'b1, 1'b0);
        send_item(3,   1'b1, 1'b1, 1'b0);
        send_item(0,   1'b0, 1'b0, 1'b1);
        // Disjoint sets intersect to nothing
        send_item(1, 1'b0, 1'b1, 1'b0);
        send_item(2, 1'b1, 1'b1, 1'b1);

        // Complement: duplicate in the universe, A reaching outside it
        write_mode(MODE_COMPL);
        send_item(4, 1'b0, 1'b1, 1'b0);
        send_item(1, 1'b0, 1'b1, 1'b0);
        send_item(4, 1'b0, 1'b1, 1'b0);
        send_item(3, 1'b0, 1'b1, 1'b0);
        send_item(2, 1'b1, 1'b1, 1'b0);
        send_item(9, 1'b1, 1'b1, 1'b1);

        // Unused mode keeps nothing
        write_mode(MODE_UNUSED);
        send_item(7, 1'b0, 1'b1, 1'b0);
        send_item(7, 1'b1, 1'b1, 1'b1);

        // Random phases, each under one op_mode; stop once the item budget is spent
        for (int phase = 0; item_count < RANDOM_ITEMS; phase++)
        begin
            write_mode(phase < 4 ? mode_list[phase] : mode_list[$urandom_range(0, 3)]);
            repeat ($urandom_range(2, 4))
            begin
                if (item_count < RANDOM_ITEMS)
                    random_run();
                if (item_count >= CALM_ITEMS)
                    idle_on = 1'b0;
            end
        end

        // Drain and watch for stray beats
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d runs: union %0d, intersection %0d, complement %0d, unused %0d",
                 board.runs, board.mode_runs[MODE_UNION], board.mode_runs[MODE_INTER],
                 board.mode_runs[MODE_COMPL], board.mode_runs[MODE_UNUSED]);
        $display("checked %0d result beats, %0d runs with dropped elements, %0d mismatches",
                 board.beats_seen, board.overflow_runs, board.errors);
        if (board.errors == 0)
            $display("sorted_set_union_intersect_complement regression: pass");
        else
            $display("sorted_set_union_intersect_complement regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ssuic_pkg.sv
hdl/ssuic_if.sv
hdl/ssuic_cell.sv
hdl/ssuic_chain.sv
hdl/sorted_set_union_intersect_complement.sv
verif/tb_sorted_set_union_intersect_complement.sv
